FILE: rtl/core/ppr_pkg.sv
// Shared types and constants for the pixel predictor residual codec.
`default_nettype none
package ppr_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_MODEL_MODE   = 2'd0;
    localparam cfg_idx_t REG_DECODE_MODE  = 2'd1;
    localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd2;
    localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd3;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_RAW   = 2'd0;
    localparam mode_t MODE_DELTA = 2'd1;
    localparam mode_t MODE_PAETH = 2'd2;

    // Neighborhood and mode seen by the datapath for one pixel.
    typedef struct packed {
        mode_t      mode;
        logic       decode;
        logic [7:0] a;     // left, zero outside the image
        logic [7:0] b;     // upper, zero outside the image
        logic [7:0] c;     // upper-left, zero outside the image
        logic [7:0] prev;  // previous pixel of the frame
    } ctx_t;

endpackage
`default_nettype wire

FILE: rtl/core/pixel_predictor_residual_codec_unit.sv
// Pixel predictor / residual codec: takes one byte per transaction in row-major
// order and returns one byte (residual when encoding, pixel when decoding) with
// a frame_end flag on the last pixel. Modes are raw, delta and Paeth. One
// transaction per clock is sustained unless m_ready stalls the output; each result
// enters the output register on the edge that accepts its input. The previous row
// lives in a RAM of MAX_WIDTH bytes whose read address runs one pixel ahead, with
// a one-entry bypass for a write and read of the same column in the same cycle.
// Any configuration write restarts the frame; the line store keeps its contents.
`default_nettype none
module pixel_predictor_residual_codec_unit #(
    parameter int MAX_WIDTH  = ppr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ppr_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_in_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [7:0]                     m_out_byte,
    output logic                                m_frame_end,
    input  wire logic                           cfg_wen,
    input  wire logic [ppr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ppr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ppr_pkg::*;

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // configuration
    mode_t                 model_mode_reg;
    logic                  decode_mode_reg;
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;

    // frame state
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [7:0]    left_reg, left_next;
    logic [7:0]    ul_reg, ul_next;
    logic [7:0]    prev_reg, prev_next;
    logic          byp_reg, byp_next;
    logic [7:0]    byp_data_reg;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    out_byte_reg;
    logic          frame_end_reg;

    logic [XW-1:0] last_col;
    logic [YW-1:0] last_row;
    logic          accept;
    logic          at_row_end;
    logic          last;
    logic [7:0]    ram_q;
    logic [7:0]    upper;
    logic [7:0]    pixel;
    logic [7:0]    result;
    ctx_t          ctx;

    assign s_ready     = !m_valid_reg || m_ready;
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_frame_end = frame_end_reg;

    // zero size acts as one, oversize clamps to the maximum
    always_comb begin
        if (image_width_reg == '0) begin
            last_col = '0;
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            last_col = XW'(MAX_WIDTH - 1);
        end else begin
            last_col = XW'(image_width_reg - CFG_DATA_W'(1));
        end
        if (image_height_reg == '0) begin
            last_row = '0;
        end else if (32'(image_height_reg) > MAX_HEIGHT) begin
            last_row = YW'(MAX_HEIGHT - 1);
        end else begin
            last_row = YW'(image_height_reg - CFG_DATA_W'(1));
        end
    end

    assign at_row_end = (col_reg == last_col);
    assign last       = at_row_end && (row_reg == last_row);
    assign upper      = byp_reg ? byp_data_reg : ram_q;

    // left and upper-left are already zero at column 0
    always_comb begin
        ctx.mode   = model_mode_reg;
        ctx.decode = decode_mode_reg;
        ctx.a      = left_reg;
        ctx.b      = (row_reg != '0) ? upper : 8'd0;
        ctx.c      = (row_reg != '0) ? ul_reg : 8'd0;
        ctx.prev   = prev_reg;
    end

    ppr_datapath u_datapath (
        .ctx     (ctx),
        .in_byte (s_in_byte),
        .pixel   (pixel),
        .result  (result)
    );

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        ul_next   = ul_reg;
        prev_next = prev_reg;
        if (cfg_wen) begin
            col_next  = '0;
            row_next  = '0;
            left_next = 8'd0;
            ul_next   = 8'd0;
            prev_next = 8'd0;
        end else if (accept) begin
            if (last) begin
                col_next  = '0;
                row_next  = '0;
                left_next = 8'd0;
                ul_next   = 8'd0;
                prev_next = 8'd0;
            end else if (at_row_end) begin
                col_next  = '0;
                row_next  = row_reg + YW'(1);
                left_next = 8'd0;
                ul_next   = 8'd0;
                prev_next = pixel;
            end else begin
                col_next  = col_reg + XW'(1);
                left_next = pixel;
                ul_next   = upper;
                prev_next = pixel;
            end
        end
        // RAM reads old data on a same-address write; forward it next cycle
        byp_next = accept && (col_reg == col_next);
    end

    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    // Line store read runs at the next pixel's column.
    ppr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH),
        .AW    (XW)
    ) u_row_store (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (pixel),
        .raddr (col_next),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_mode_reg   <= MODE_RAW;
            decode_mode_reg  <= 1'b0;
            image_width_reg  <= CFG_DATA_W'(1);
            image_height_reg <= CFG_DATA_W'(1);
            col_reg          <= '0;
            row_reg          <= '0;
            left_reg         <= 8'd0;
            ul_reg           <= 8'd0;
            prev_reg         <= 8'd0;
            byp_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_index)
                    REG_MODEL_MODE:   model_mode_reg   <= cfg_data[1:0];
                    REG_DECODE_MODE:  decode_mode_reg  <= cfg_data[0];
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default: ;
                endcase
            end
            col_reg     <= col_next;
            row_reg     <= row_next;
            left_reg    <= left_next;
            ul_reg      <= ul_next;
            prev_reg    <= prev_next;
            byp_reg     <= byp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byp_data_reg <= pixel;
        if (accept) begin
            out_byte_reg  <= result;
            frame_end_reg <= last;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ppr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/ppr_datapath.sv
// Prediction select, Paeth predictor and residual encode/decode for one pixel.
`default_nettype none
module ppr_datapath (
    input  wire ppr_pkg::ctx_t ctx,
    input  wire logic [7:0]    in_byte,
    output logic      [7:0]    pixel,
    output logic      [7:0]    result
);
    import ppr_pkg::*;

    logic signed [9:0] pa, pb, pc;
    logic        [7:0] paeth;
    logic        [7:0] pred;

    // p - a = b - c, p - b = a - c, p - c = a + b - 2c
    always_comb begin
        pa = $signed({2'b00, ctx.b}) - $signed({2'b00, ctx.c});
        pb = $signed({2'b00, ctx.a}) - $signed({2'b00, ctx.c});
        pc = pa + pb;
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) begin
            paeth = ctx.a;
        end else if (pb <= pc) begin
            paeth = ctx.b;
        end else begin
            paeth = ctx.c;
        end
    end

    always_comb begin
        case (ctx.mode)
            MODE_DELTA: pred = ctx.prev;
            MODE_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
    end

    always_comb begin
        if (ctx.decode) begin
            pixel  = pred + in_byte;
            result = pixel;
        end else begin
            pixel  = in_byte;
            result = in_byte - pred;
        end
    end

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the pixel predictor residual codec unit.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppr_pkg::*;

    localparam int          LINE_MAX      = MAX_WIDTH_DEF;
    localparam int          ROWS_MAX      = MAX_HEIGHT_DEF;
    localparam int          WATCHDOG_MAX  = 1000;
    localparam int          SETTLE_CYCLES = 2;
    localparam int          RANDOM_ITEMS  = 900;
    localparam mode_t       MODE_UNUSED   = 2'd3;

    // content styles for random frames
    localparam int STY_NOISE   = 0;
    localparam int STY_WALK    = 1;
    localparam int STY_EXTREME = 2;
    localparam int STY_RUNS    = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } codec_res_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_in_byte   = 8'h00;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [7:0]            m_out_byte;
    logic                  m_frame_end;
    logic                  cfg_wen     = 1'b0;
    cfg_idx_t              cfg_index   = REG_MODEL_MODE;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    pixel_predictor_residual_codec_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 aclk = ~aclk;

    // ---------------- codec prediction state ----------------
    mode_t             cur_mode   = MODE_RAW;
    bit                cur_decode = 1'b0;
    bit [12:0]         cur_width  = 13'd1;
    bit [12:0]         cur_height = 13'd1;
    bit [7:0]          line_mem [LINE_MAX];
    bit [7:0]          left_pix, upleft_pix, prev_pix;
    int unsigned       col_pos, row_pos;

    logic [7:0]        pixel_q [$];
    codec_res_t        result_q [$];

    int                mismatches  = 0;
    int                n_in        = 0;
    int                n_out       = 0;
    int                n_frames    = 0;
    int                n_configs   = 0;
    int                idle_cycles = 0;

    function automatic void clear_frame();
        left_pix   = 8'h00;
        upleft_pix = 8'h00;
        prev_pix   = 8'h00;
        col_pos    = 0;
        row_pos    = 0;
    endfunction

    function automatic int unsigned eff_size(bit [12:0] v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic codec_res_t codec_step(input logic [7:0] v);
        int unsigned w, h, x, y;
        int          p, pa, pb, pc;
        bit [7:0]    upper, pred, pix, a, b, c;
        bit          last;
        codec_res_t  r;
        w = eff_size(cur_width, LINE_MAX);
        h = eff_size(cur_height, ROWS_MAX);
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = (row_pos >= h) ? h - 1 : row_pos;
        upper = line_mem[x];
        if (cur_mode == MODE_DELTA) begin
            pred = prev_pix;
        end else if (cur_mode == MODE_PAETH) begin
            a  = (x != 0) ? left_pix : 8'h00;
            b  = (y != 0) ? upper : 8'h00;
            c  = (x != 0 && y != 0) ? upleft_pix : 8'h00;
            p  = int'(a) + int'(b) - int'(c);
            pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
            pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
            pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
            if (pa <= pb && pa <= pc) pred = a;
            else if (pb <= pc)        pred = b;
            else                      pred = c;
        end else begin
            pred = 8'h00;   // raw and the unused mode code
        end
        if (cur_decode) begin
            pix        = pred + v;
            r.out_byte = pix;
        end else begin
            pix        = v;
            r.out_byte = v - pred;
        end
        last        = (x == w - 1) && (y == h - 1);
        r.frame_end = last;
        line_mem[x] = pix;
        upleft_pix  = upper;
        left_pix    = pix;
        prev_pix    = pix;
        if (last) begin
            clear_frame();
        end else if (x + 1 >= w) begin
            col_pos    = 0;
            row_pos    = y + 1;
            left_pix   = 8'h00;
            upleft_pix = 8'h00;
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
        return r;
    endfunction

    // ---------------- sender ----------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                result_q.insert(result_q.size(), codec_step(s_in_byte));
                n_in++;
            end
            if (s_valid && !s_ready) begin
                // hold the pending transaction
            end else if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                s_valid   <= 1'b1;
                s_in_byte <= pixel_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                             : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------
    int       stall_kind = 0;
    int       stall_left = 0;
    bit [3:0] stall_tick = '0;

    task automatic note_mismatch(string what, codec_res_t want);
        if (mismatches < 10)
            $display("MISMATCH %s: expected byte %02h end %0b, got byte %02h end %0b",
                     what, want.out_byte, want.frame_end, m_out_byte, m_frame_end);
        mismatches++;
    endtask

    always @(posedge aclk) begin : rx_side
        codec_res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_out++;
                if (m_frame_end === 1'b1) n_frames++;
                if (result_q.size() == 0) begin
                    note_mismatch("unexpected result", '0);
                end else begin
                    want = result_q.pop_front();
                    if (m_out_byte !== want.out_byte || m_frame_end !== want.frame_end)
                        note_mismatch($sformatf("result %0d", n_out - 1), want);
                end
            end
            if (stall_left == 0) begin
                stall_kind = $urandom_range(0, 3);
                stall_left = $urandom_range(32, 300);
            end else begin
                stall_left--;
            end
            stall_tick++;
            case (stall_kind)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (stall_tick[2:0] < 3'd5);
            endcase
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if (!aresetn || cfg_wen || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_MAX);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    // sampled at the falling edge, once the sender's updates have settled
    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_valid || result_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // the write lands on the next edge; no pixel is in flight then
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_MODEL_MODE:  cur_mode   = mode_t'(val[1:0]);
            REG_DECODE_MODE: cur_decode = val[0];
            REG_IMAGE_WIDTH: cur_width  = val;
            default:         cur_height = val;
        endcase
        clear_frame();
    endtask

    task automatic load_config(mode_t m, bit dec, bit [12:0] w, bit [12:0] h);
        wait_drained();
        write_reg(REG_MODEL_MODE, {11'($urandom), m});
        write_reg(REG_DECODE_MODE, {12'($urandom), dec});
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        @(posedge aclk);
        cfg_wen <= 1'b0;
        n_configs++;
    endtask

    task automatic push_random(int n, int style);
        bit [7:0] walk;
        bit [7:0] b;
        walk = 8'($urandom);
        for (int k = 0; k < n; k++) begin
            case (style)
                STY_NOISE: b = 8'($urandom);
                STY_WALK: begin
                    walk = walk + 8'($urandom_range(0, 6)) - 8'd3;
                    b    = walk;
                end
                STY_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        2:       b = 8'h7F;
                        default: b = 8'h80;
                    endcase
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) walk = 8'($urandom);
                    b = walk;
                end
            endcase
            pixel_q.insert(pixel_q.size(), b);
        end
    endtask

    initial begin
        mode_t       m;
        bit [12:0]   w, h;
        int unsigned area;
        int          n, rand_items;
        clear_frame();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: raw encode of a 1x1 frame
        pixel_q = {8'h00, 8'hFF, 8'hA5};
        // Paeth encode, 3x2, extremes in both rows
        load_config(MODE_PAETH, 1'b0, 13'd3, 13'd2);
        pixel_q = {8'h0A, 8'hFA, 8'h00, 8'hFF, 8'h80, 8'h01};
        // Paeth decode, 2x2
        load_config(MODE_PAETH, 1'b1, 13'd2, 13'd2);
        pixel_q = {8'hFF, 8'h01, 8'h80, 8'h7F};
        // delta encode across a frame boundary
        load_config(MODE_DELTA, 1'b0, 13'd4, 13'd1);
        pixel_q = {8'h00, 8'hFF, 8'h01, 8'h80, 8'h55};
        // unused mode code with zero-sized frame
        load_config(MODE_UNUSED, 1'b1, 13'd0, 13'd0);
        pixel_q = {8'h12, 8'hED};
        // zero width, three rows of Paeth
        load_config(MODE_PAETH, 1'b0, 13'd0, 13'd3);
        pixel_q = {8'h40, 8'hC0, 8'h00};

        // oversize width, start of the first line
        load_config(MODE_PAETH, 1'b1, 13'h1FFF, 13'd1);
        push_random(48, STY_WALK);
        // oversize height, partial frame
        load_config(MODE_DELTA, 1'b0, 13'd2, 13'h1FFF);
        push_random(40, STY_NOISE);

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       m = MODE_RAW;
                1, 2:    m = MODE_DELTA;
                7:       m = MODE_UNUSED;
                default: m = MODE_PAETH;
            endcase
            case ($urandom_range(0, 9))
                0:       w = 13'd0;
                1:       w = 13'($urandom_range(17, 64));
                default: w = 13'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       h = 13'd0;
                1:       h = 13'($urandom_range(7, 12));
                default: h = 13'($urandom_range(1, 6));
            endcase
            area = eff_size(w, LINE_MAX) * eff_size(h, ROWS_MAX);
            // mostly whole frames, sometimes a broken one at the tail
            n = area * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, area);
            if (n > 300) n = $urandom_range(area < 300 ? area : 1, 300);
            load_config(m, 1'($urandom), w, h);
            push_random(n, $urandom_range(STY_NOISE, STY_RUNS));
            rand_items += n;
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (result_q.size() != 0)
            $display("%0d expected results never arrived", result_q.size());
        $display("Covered %0d configurations: raw, delta, Paeth, unused mode, both directions,",
                 n_configs + 1);
        $display("zero and oversize frames; %0d pixels in, %0d results, %0d frame ends, %0d bad",
                 n_in, n_out, n_frames, mismatches);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/ppr_pkg.sv
rtl/core/ppr_ram.sv
rtl/core/ppr_datapath.sv
rtl/core/pixel_predictor_residual_codec_unit.sv
dv/tb_top.sv
